FILE: hw/rtl/bchd_pkg.sv
// ----------------------------------------------------------------------------
// Button click and hold detector package
// Types, register map, codes and limits that the detector modules share.
// ----------------------------------------------------------------------------
package bchd_pkg;

  localparam int unsigned BUTTONS = 8;

  localparam int unsigned CNT_W  = 20;
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  localparam logic [9:0]  MS_PER_S           = 10'd1000;
  localparam logic [9:0]  MOMENTARY_GUARD_MS = 10'd500;
  localparam logic [7:0]  CLICK_MAX          = 8'hff;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    REG_CLICK_GAP  = 3'd0,
    REG_HOLD_THR   = 3'd1,
    REG_HOLD_REP   = 3'd2,
    REG_RESET_HOLD = 3'd3,
    REG_MODES      = 3'd4,
    REG_ACTIONS    = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    FUNC_TICK    = 2'd0,
    FUNC_PRESS   = 2'd1,
    FUNC_RELEASE = 2'd2,
    FUNC_NONE    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    EV_CLICK   = 2'd0,
    EV_HOLD    = 2'd1,
    EV_COMMAND = 2'd2,
    EV_FACTORY = 2'd3
  } event_t;

  typedef enum logic [1:0] {
    CMD_OFF    = 2'd0,
    CMD_ON     = 2'd1,
    CMD_TOGGLE = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_TOGGLE    = 2'd0,
    MODE_MOMENTARY = 2'd1,
    MODE_MULTI     = 2'd2,
    MODE_MULTI_ALT = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ACT_ON_OFF = 2'd0,
    ACT_OFF_ON = 2'd1,
    ACT_TOGGLE = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_WAIT_MODE = 3'd1,
    PH_CLICKS    = 3'd2,
    PH_HOLD      = 3'd3,
    PH_WAIT_END  = 3'd4
  } phase_t;

  typedef struct packed {
    logic [1:0] func;
    logic [2:0] button;
  } in_item_t;

  typedef struct packed {
    logic [1:0] event_res;
    logic [2:0] which_button;
    logic [7:0] click_total;
    logic [1:0] command;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] click_gap_ms;
    logic [15:0] hold_threshold_ms;
    logic [15:0] hold_repeat_ms;
    logic [7:0]  reset_hold_s;
    logic [15:0] button_modes;
    logic [15:0] button_actions;
  } cfg_t;

  typedef struct packed {
    logic      push0;
    logic      push1;
    out_item_t res0;
    out_item_t res1;
  } push_t;

  function automatic out_item_t make_res(event_t ev, logic [2:0] btn, logic [7:0] clicks,
                                         cmd_t cmd, logic last);
    out_item_t r;
    r.event_res    = ev;
    r.which_button = btn;
    r.click_total  = clicks;
    r.command      = cmd;
    r.last         = last;
    return r;
  endfunction

endpackage

FILE: hw/rtl/button_click_hold_detector_core.sv
// ----------------------------------------------------------------------------
// Button click and hold detector
// Counts clicks, detects holds and factory-reset presses, and issues
// on/off/toggle commands from a stream of millisecond ticks and key events.
// ----------------------------------------------------------------------------
// The block takes one item (tick, press or release) in every cycle while
// in_stall is low and updates its phase and elapsed-time counters in that
// same cycle. Results go into a four-entry queue that feeds the output
// channel one transfer a cycle while out_stall is low. A release can produce
// two results (factory reset then a command), and the momentary press before
// it one more; in_stall rises whenever the queue holds more than two results,
// so two free slots are there whenever an item is taken.
module button_click_hold_detector_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  bchd_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output bchd_pkg::out_item_t         out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bchd_pkg::ADDR_W-1:0] paddr,
  input  logic [bchd_pkg::DATA_W-1:0] pwdata,
  output logic [bchd_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import bchd_pkg::*;

  cfg_t  cfg;
  push_t push;
  logic  accept;

  phase_t           phase_r, phase_nxt;
  logic             act_valid_r, act_valid_nxt;
  logic [2:0]       act_idx_r, act_idx_nxt;
  logic [7:0]       clicks_r, clicks_nxt;
  logic [CNT_W-1:0] press_el_r, press_el_nxt;
  logic [CNT_W-1:0] action_el_r, action_el_nxt;
  logic [CNT_W-1:0] reset_el_r, reset_el_nxt;

  logic [CNT_W-1:0] press_inc, action_inc, reset_inc;
  logic [17:0]      reset_lim;
  logic             btn_ok;
  mode_t            press_mode;
  action_t          press_act, rel_act;
  logic             click_fire, hold_first, hold_rep;
  logic             factory_fire, press_cmd, rel_cmd;
  cmd_t             press_cmd_val, rel_cmd_val;
  func_t            func;

  bchd_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bchd_res_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .no_room   (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign accept = in_valid && !in_stall;
  assign func   = func_t'(in_data.func);

  assign press_inc  = (press_el_r == '1) ? press_el_r : press_el_r + CNT_W'(1);
  assign action_inc = (action_el_r == '1) ? action_el_r : action_el_r + CNT_W'(1);
  assign reset_inc  = (reset_el_r == '1) ? reset_el_r : reset_el_r + CNT_W'(1);
  assign reset_lim  = 18'(cfg.reset_hold_s) * 18'(MS_PER_S);

  assign btn_ok     = 32'(in_data.button) < BUTTONS;
  assign press_mode = mode_t'(cfg.button_modes[{in_data.button, 1'b0} +: 2]);
  assign press_act  = action_t'(cfg.button_actions[{in_data.button, 1'b0} +: 2]);
  assign rel_act    = action_t'(cfg.button_actions[{act_idx_r, 1'b0} +: 2]);

  assign click_fire = (phase_r == PH_CLICKS) && (action_inc > CNT_W'(cfg.click_gap_ms));
  assign hold_first = (phase_r == PH_WAIT_MODE)
                      && (press_inc > CNT_W'(cfg.hold_threshold_ms));
  assign hold_rep   = (phase_r == PH_HOLD) && (press_inc > CNT_W'(cfg.hold_repeat_ms));

  assign factory_fire = reset_el_r > CNT_W'(reset_lim);
  assign press_cmd    = btn_ok && (press_mode == MODE_MOMENTARY) && (press_act != ACT_NONE);
  assign rel_cmd      = (phase_r == PH_WAIT_END) && act_valid_r
                        && (action_el_r > CNT_W'(MOMENTARY_GUARD_MS))
                        && (rel_act != ACT_NONE);

  always_comb begin
    case (press_act)
      ACT_ON_OFF: press_cmd_val = CMD_ON;
      ACT_OFF_ON: press_cmd_val = CMD_OFF;
      default:    press_cmd_val = CMD_TOGGLE;
    endcase
    case (rel_act)
      ACT_ON_OFF: rel_cmd_val = CMD_OFF;
      ACT_OFF_ON: rel_cmd_val = CMD_ON;
      default:    rel_cmd_val = CMD_TOGGLE;
    endcase
  end

  // Next state.
  always_comb begin
    phase_nxt     = phase_r;
    act_valid_nxt = act_valid_r;
    act_idx_nxt   = act_idx_r;
    clicks_nxt    = clicks_r;
    press_el_nxt  = press_el_r;
    action_el_nxt = action_el_r;
    reset_el_nxt  = reset_el_r;
    unique case (func)
      FUNC_TICK: begin
        press_el_nxt  = press_inc;
        action_el_nxt = action_inc;
        reset_el_nxt  = reset_inc;
        if (click_fire) begin
          phase_nxt  = PH_IDLE;
          clicks_nxt = '0;
        end else if (hold_first) begin
          phase_nxt    = PH_HOLD;
          press_el_nxt = '0;
        end else if (hold_rep) begin
          press_el_nxt = '0;
        end
      end
      FUNC_PRESS: begin
        if (btn_ok) begin
          reset_el_nxt  = '0;
          press_el_nxt  = '0;
          act_valid_nxt = 1'b1;
          act_idx_nxt   = in_data.button;
          if ((press_mode == MODE_MOMENTARY) || (press_mode == MODE_TOGGLE)) begin
            phase_nxt = PH_WAIT_END;
          end else begin
            phase_nxt = PH_WAIT_MODE;
          end
        end
      end
      FUNC_RELEASE: begin
        if (phase_r == PH_WAIT_MODE) begin
          if (clicks_r != CLICK_MAX) begin
            clicks_nxt = clicks_r + 8'd1;
          end
          action_el_nxt = '0;
          phase_nxt     = PH_CLICKS;
        end else begin
          act_valid_nxt = 1'b0;
          phase_nxt     = PH_IDLE;
        end
      end
      default: ;
    endcase
  end

  // Results.
  always_comb begin
    push.push0 = 1'b0;
    push.push1 = 1'b0;
    push.res0  = make_res(EV_CLICK, act_idx_r, clicks_r, CMD_OFF, 1'b1);
    push.res1  = make_res(EV_COMMAND, act_idx_r, 8'd0, rel_cmd_val, 1'b1);
    unique case (func)
      FUNC_TICK: begin
        if (click_fire) begin
          push.push0 = accept;
        end else if (hold_first || hold_rep) begin
          push.push0 = accept;
          push.res0  = make_res(EV_HOLD, act_idx_r, 8'd0, CMD_OFF, 1'b1);
        end
      end
      FUNC_PRESS: begin
        push.push0 = accept && press_cmd;
        push.res0  = make_res(EV_COMMAND, in_data.button, 8'd0, press_cmd_val, 1'b1);
      end
      FUNC_RELEASE: begin
        if (factory_fire) begin
          push.push0 = accept;
          push.push1 = accept && rel_cmd;
          push.res0  = make_res(EV_FACTORY, act_valid_r ? act_idx_r : 3'd0, 8'd0,
                                CMD_OFF, !rel_cmd);
        end else begin
          push.push0 = accept && rel_cmd;
          push.res0  = make_res(EV_COMMAND, act_idx_r, 8'd0, rel_cmd_val, 1'b1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      act_valid_r <= 1'b0;
      act_idx_r   <= '0;
      clicks_r    <= '0;
      press_el_r  <= '0;
      action_el_r <= '0;
      reset_el_r  <= '0;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      act_valid_r <= act_valid_nxt;
      act_idx_r   <= act_idx_nxt;
      clicks_r    <= clicks_nxt;
      press_el_r  <= press_el_nxt;
      action_el_r <= action_el_nxt;
      reset_el_r  <= reset_el_nxt;
    end
  end

endmodule

FILE: hw/rtl/bchd_cfg_regs.sv
// ----------------------------------------------------------------------------
// Button click and hold detector configuration registers
// APB-style register file holding the timing limits and per-button settings.
// ----------------------------------------------------------------------------
module bchd_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bchd_pkg::ADDR_W-1:0] paddr,
  input  logic [bchd_pkg::DATA_W-1:0] pwdata,
  output logic [bchd_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output bchd_pkg::cfg_t             cfg
);
  import bchd_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.click_gap_ms      <= 16'd300;
      cfg_r.hold_threshold_ms <= 16'd1000;
      cfg_r.hold_repeat_ms    <= 16'd500;
      cfg_r.reset_hold_s      <= 8'd10;
      cfg_r.button_modes      <= 16'haaaa;
      cfg_r.button_actions    <= 16'h0000;
    end else if (wr_en) begin
      unique case (idx)
        REG_CLICK_GAP:  cfg_r.click_gap_ms      <= pwdata[15:0];
        REG_HOLD_THR:   cfg_r.hold_threshold_ms <= pwdata[15:0];
        REG_HOLD_REP:   cfg_r.hold_repeat_ms    <= pwdata[15:0];
        REG_RESET_HOLD: cfg_r.reset_hold_s      <= pwdata[7:0];
        REG_MODES:      cfg_r.button_modes      <= pwdata[15:0];
        REG_ACTIONS:    cfg_r.button_actions    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CLICK_GAP:  prdata = {16'd0, cfg_r.click_gap_ms};
      REG_HOLD_THR:   prdata = {16'd0, cfg_r.hold_threshold_ms};
      REG_HOLD_REP:   prdata = {16'd0, cfg_r.hold_repeat_ms};
      REG_RESET_HOLD: prdata = {24'd0, cfg_r.reset_hold_s};
      REG_MODES:      prdata = {16'd0, cfg_r.button_modes};
      REG_ACTIONS:    prdata = {16'd0, cfg_r.button_actions};
      default:        prdata = '0;
    endcase
  end

endmodule

FILE: hw/rtl/bchd_res_queue.sv
// ----------------------------------------------------------------------------
// Button click and hold detector result queue
// Small queue: up to two results in a cycle, one out a cycle if not stalled.
// ----------------------------------------------------------------------------
module bchd_res_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  bchd_pkg::push_t     push,
  output logic                no_room,
  output logic                out_valid,
  input  logic                out_stall,
  output bchd_pkg::out_item_t out_data
);
  import bchd_pkg::*;

  out_item_t         mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic [QPTR_W-1:0] wr_ptr_p1;
  logic              pop;
  logic [QCNT_W-1:0] n_push;

  assign no_room   = count_r > QCNT_W'(QUEUE_DEPTH - 2);
  assign out_valid = count_r != '0;
  assign out_data  = mem[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  assign wr_ptr_p1 = wr_ptr_r + QPTR_W'(1);
  assign n_push    = QCNT_W'(push.push0) + QCNT_W'(push.push1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(n_push);
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + n_push - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.push0) begin
      mem[wr_ptr_r] <= push.res0;
    end
    if (push.push1) begin
      mem[wr_ptr_p1] <= push.res1;
    end
  end

endmodule
